[rtl/psfi_pkg.sv]
`timescale 1ns / 1ps
package psfi_pkg;

	localparam int MAX_GRID_SIDE = 3;
	localparam int CELLS         = MAX_GRID_SIDE * MAX_GRID_SIDE;
	localparam int CELL_W        = $clog2(CELLS);
	localparam int SLOT_W        = 4;
	localparam int POS_W         = 24;
	localparam int POS_FRAC_BITS = 8;
	localparam int DIM_W         = 16;
	localparam int SIDE_W        = 4;
	localparam int PARAM_W       = 24;
	localparam int LANES         = 4;
	localparam int WB            = 16;              // weight fraction bits
	localparam int T_W           = WB + 1;          // weight 0..1.0
	localparam int WP_W          = DIM_W + POS_FRAC_BITS;
	localparam int D_W           = WP_W + 1;        // centre spacing 2*wp
	localparam int U_W           = POS_W + 3;       // position times 2*side
	localparam int STEPS         = 8;
	localparam int BITS_PER_STEP = WB / STEPS;
	localparam int DIF_W         = PARAM_W + 1;
	localparam int A_W           = PARAM_W + WB + 2;
	localparam int SPLIT         = A_W / 2;
	localparam int S_W           = A_W + WB;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SIDE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [SIDE_W-1:0] side;
	} cfg_t;

	typedef logic [LANES-1:0][PARAM_W-1:0] pvec_t;

	typedef struct packed {
		logic                          query;
		logic                          unsup;
		logic                          zx;
		logic                          zy;
		logic [SLOT_W-1:0]             slot;
		logic [3:0][CELL_W-1:0]        addr;   // c00, c01, c10, c11
		pvec_t                         ld;
		logic [D_W-1:0]                dx;
		logic [D_W-1:0]                dy;
	} item_t;

	typedef struct packed {
		logic unsup;
		logic zx;
		logic zy;
	} qctl_t;

	typedef struct packed {
		logic [PARAM_W-1:0] v00;
		logic [PARAM_W-1:0] v10;
		logic [DIF_W-1:0]   dy0;
		logic [DIF_W-1:0]   dy1;
	} lane_t;

	typedef struct packed {
		logic [D_W-1:0] r;
		logic [T_W-1:0] q;
	} dv_t;

	// image size in position units, zero treated as one
	function automatic logic [WP_W-1:0] pos_scale(input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] m;
		m = (n == '0) ? DIM_W'(1) : n;
		return {m, {POS_FRAC_BITS{1'b0}}};
	endfunction

	function automatic dv_t div_stage(input dv_t a, input logic [D_W-1:0] d);
		dv_t          x;
		logic [D_W:0] r2;
		x = a;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			r2 = {x.r, 1'b0};
			if (r2 >= {1'b0, d}) begin
				x.r = D_W'(r2 - {1'b0, d});
				x.q = {x.q[T_W-2:0], 1'b1};
			end else begin
				x.r = r2[D_W-1:0];
				x.q = {x.q[T_W-2:0], 1'b0};
			end
		end
		return x;
	endfunction

endpackage

[rtl/psf_grid_parameter_interpolator.sv]
`timescale 1ns / 1ps
// Queries pass front stage, queue, divider and multiply pipe to strobe done; loads give none.
// Throughput: one word per cycle; the weight divider and the multiply pipe are fully
// pipelined, so busy only rises if the two-entry front queue fills.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous): config returns to 4096 x 4096, side 1, the pipeline empties.
// The cell store is not cleared; cells read before being loaded return undefined values.
module psf_grid_parameter_interpolator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  command,
	input  logic [psfi_pkg::SLOT_W-1:0]           cell_slot,
	input  logic signed [psfi_pkg::PARAM_W-1:0]   load_width_term,
	input  logic signed [psfi_pkg::PARAM_W-1:0]   load_cos_term,
	input  logic signed [psfi_pkg::PARAM_W-1:0]   load_sin_term,
	input  logic signed [psfi_pkg::PARAM_W-1:0]   load_wing_term,
	input  logic [psfi_pkg::POS_W-1:0]            pos_x,
	input  logic [psfi_pkg::POS_W-1:0]            pos_y,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [psfi_pkg::DIM_W-1:0]            cfg_data,
	output logic                                  done,
	output logic signed [psfi_pkg::PARAM_W-1:0]   width_term,
	output logic signed [psfi_pkg::PARAM_W-1:0]   cos_term,
	output logic signed [psfi_pkg::PARAM_W-1:0]   sin_term,
	output logic signed [psfi_pkg::PARAM_W-1:0]   wing_term,
	output logic                                  status
);

	psfi_pkg::cfg_t  cfg_q;
	psfi_pkg::pvec_t load_terms;
	psfi_pkg::pvec_t terms;
	psfi_pkg::item_t fr_item;
	psfi_pkg::item_t q_head;
	logic            fr_push;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= psfi_pkg::DIM_W'(4096);
			cfg_q.height <= psfi_pkg::DIM_W'(4096);
			cfg_q.side   <= psfi_pkg::SIDE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (psfi_pkg::cfg_reg_t'(cfg_index))
				psfi_pkg::REG_WIDTH: begin
					cfg_q.width <= cfg_data;
				end
				psfi_pkg::REG_HEIGHT: begin
					cfg_q.height <= cfg_data;
				end
				psfi_pkg::REG_SIDE: begin
					cfg_q.side <= cfg_data[psfi_pkg::SIDE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign load_terms = {load_wing_term, load_sin_term, load_cos_term, load_width_term};

	psfi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.cell_slot  (cell_slot),
		.load_terms (load_terms),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.full       (q_full),
		.push       (fr_push),
		.item       (fr_item)
	);

	psfi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.din    (fr_item),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_head)
	);

	psfi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.done       (done),
		.terms      (terms),
		.status     (status)
	);

	assign width_term = terms[0];
	assign cos_term   = terms[1];
	assign sin_term   = terms[2];
	assign wing_term  = terms[3];

endmodule

[rtl/psfi_queue.sv]
`timescale 1ns / 1ps
module psfi_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psfi_pkg::item_t  din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output psfi_pkg::item_t  dout
);

	psfi_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

endmodule

[rtl/psfi_front.sv]
`timescale 1ns / 1ps
module psfi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psfi_pkg::cfg_t                cfg,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [psfi_pkg::SLOT_W-1:0]   cell_slot,
	input  psfi_pkg::pvec_t               load_terms,
	input  logic [psfi_pkg::POS_W-1:0]    pos_x,
	input  logic [psfi_pkg::POS_W-1:0]    pos_y,
	input  logic                          full,
	output logic                          push,
	output psfi_pkg::item_t               item
);

	localparam int U_W    = psfi_pkg::U_W;
	localparam int D_W    = psfi_pkg::D_W;
	localparam int CELL_W = psfi_pkg::CELL_W;

	logic                          vld_s1;
	logic                          cmd_s1;
	logic [psfi_pkg::SLOT_W-1:0]   slot_s1;
	psfi_pkg::pvec_t               ld_s1;
	logic [U_W-1:0]                u_s1;
	logic [U_W-1:0]                v_s1;

	logic                          accept;
	logic                          sel3;
	logic [U_W-1:0]                u_in, v_in, px, py;

	assign busy   = vld_s1 && full;
	assign accept = start && !busy;
	assign push   = vld_s1 && !full;
	assign sel3   = (cfg.side == psfi_pkg::SIDE_W'(psfi_pkg::MAX_GRID_SIDE));

	// scale by 2*side so cell centres sit on odd multiples of the image size
	always_comb begin
		px   = U_W'(pos_x);
		py   = U_W'(pos_y);
		u_in = U_W'((px << 2) + (sel3 ? (px << 1) : '0));
		v_in = U_W'((py << 2) + (sel3 ? (py << 1) : '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!busy) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			slot_s1 <= cell_slot;
			ld_s1   <= load_terms;
			u_s1    <= u_in;
			v_s1    <= v_in;
		end
	end

	logic [U_W-1:0]          wp1, wp2, wp3, wp5, hp1, hp2, hp3, hp5;
	logic                    left, right, low, high, xa, ya;
	logic                    unsup, single;
	logic signed [U_W:0]     dxs, dys;
	logic [D_W-1:0]          dxc, dyc;
	logic [CELL_W-1:0]       c00, c01, c10, c11, sv, xc, yc, cc, ea, eb;

	always_comb begin
		wp1 = U_W'(psfi_pkg::pos_scale(cfg.width));
		hp1 = U_W'(psfi_pkg::pos_scale(cfg.height));
		wp2 = wp1 << 1;
		hp2 = hp1 << 1;
		wp3 = U_W'(wp1 + wp2);
		hp3 = U_W'(hp1 + hp2);
		wp5 = U_W'(wp3 + wp2);
		hp5 = U_W'(hp3 + hp2);

		unsup  = (cfg.side == '0) ||
		         (cfg.side > psfi_pkg::SIDE_W'(psfi_pkg::MAX_GRID_SIDE));
		single = (cfg.side == psfi_pkg::SIDE_W'(1));

		left  = u_s1 < wp1;
		right = u_s1 > (sel3 ? wp5 : wp3);
		low   = v_s1 < hp1;
		high  = v_s1 > (sel3 ? hp5 : hp3);
		// middle centre only exists on a 3-wide grid; exactly half belongs left/low
		xa    = sel3 && (u_s1 > wp3);
		ya    = sel3 && (v_s1 > hp3);

		dxs = $signed({1'b0, u_s1}) - $signed({1'b0, (xa ? wp3 : wp1)});
		dys = $signed({1'b0, v_s1}) - $signed({1'b0, (ya ? hp3 : hp1)});
		if (dxs < 0) begin
			dxc = '0;
		end else if (dxs > $signed({1'b0, wp2})) begin
			dxc = D_W'(wp2);
		end else begin
			dxc = D_W'(dxs);
		end
		if (dys < 0) begin
			dyc = '0;
		end else if (dys > $signed({1'b0, hp2})) begin
			dyc = D_W'(hp2);
		end else begin
			dyc = D_W'(dys);
		end

		sv  = CELL_W'(cfg.side);
		c00 = CELL_W'((xa ? CELL_W'(3) : CELL_W'(0)) + CELL_W'(ya));
		c01 = CELL_W'(c00 + CELL_W'(1));
		c10 = CELL_W'(c00 + sv);
		c11 = CELL_W'(c10 + CELL_W'(1));
		xc  = left ? '0 : CELL_W'(sv - CELL_W'(1));
		yc  = low  ? '0 : CELL_W'(sv - CELL_W'(1));
		cc  = CELL_W'(xc * sv + yc);
		ea  = left ? c00 : c10;
		eb  = left ? c01 : c11;
	end

	always_comb begin
		item       = '0;
		item.query = (cmd_s1 == psfi_pkg::CMD_QUERY);
		item.slot  = slot_s1;
		item.ld    = ld_s1;
		item.dx    = dxc;
		item.dy    = dyc;
		priority if (unsup) begin
			item.unsup = 1'b1;
			item.zx    = 1'b1;
			item.zy    = 1'b1;
		end else if (single) begin
			item.zx = 1'b1;
			item.zy = 1'b1;
		end else if ((left || right) && (low || high)) begin
			item.zx   = 1'b1;
			item.zy   = 1'b1;
			item.addr = {cc, cc, cc, cc};
		end else if (left || right) begin
			// linear along y between two centres of one column
			item.zx   = 1'b1;
			item.addr = {eb, ea, eb, ea};
		end else if (low || high) begin
			item.zy   = 1'b1;
			item.addr = {(low ? c10 : c11), (low ? c10 : c11),
			             (low ? c00 : c01), (low ? c00 : c01)};
		end else begin
			item.addr = {c11, c10, c01, c00};
		end
	end

endmodule

[rtl/psfi_back.sv]
`timescale 1ns / 1ps
module psfi_back (
	input  logic             clk,
	input  logic             arst_n,
	input  psfi_pkg::cfg_t   cfg,
	input  logic             head_valid,
	input  psfi_pkg::item_t  head,
	output logic             pop,
	output logic             done,
	output psfi_pkg::pvec_t  terms,
	output logic             status
);

	localparam int STEPS   = psfi_pkg::STEPS;
	localparam int LANES   = psfi_pkg::LANES;
	localparam int PARAM_W = psfi_pkg::PARAM_W;
	localparam int D_W     = psfi_pkg::D_W;
	localparam int T_W     = psfi_pkg::T_W;
	localparam int WB      = psfi_pkg::WB;
	localparam int A_W     = psfi_pkg::A_W;
	localparam int SPLIT   = psfi_pkg::SPLIT;
	localparam int S_W     = psfi_pkg::S_W;
	localparam int DIF_W   = psfi_pkg::DIF_W;
	localparam int R_W     = S_W - 2 * WB;
	localparam int LAT     = STEPS + 7;
	localparam logic signed [R_W-1:0] RMAX = R_W'(2 ** (PARAM_W - 1) - 1);
	localparam logic signed [R_W-1:0] RMIN = -R_W'(2 ** (PARAM_W - 1));

	assign pop = head_valid;

	logic [psfi_pkg::WP_W-1:0] wp, hp;
	logic [D_W-1:0]            dw, dh;

	assign wp = psfi_pkg::pos_scale(cfg.width);
	assign hp = psfi_pkg::pos_scale(cfg.height);
	assign dw = {wp, 1'b0};
	assign dh = {hp, 1'b0};

	// two copies of the cell store give four reads a cycle
	psfi_pkg::pvec_t mem_a [psfi_pkg::CELLS];
	psfi_pkg::pvec_t mem_b [psfi_pkg::CELLS];
	psfi_pkg::pvec_t rd00_q, rd01_q, rd10_q, rd11_q;
	logic            wr_en;

	assign wr_en = pop && !head.query &&
	               (head.slot < psfi_pkg::SLOT_W'(psfi_pkg::CELLS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[head.slot[psfi_pkg::CELL_W-1:0]] <= head.ld;
			mem_b[head.slot[psfi_pkg::CELL_W-1:0]] <= head.ld;
		end
		rd00_q <= mem_a[head.addr[0]];
		rd01_q <= mem_a[head.addr[1]];
		rd10_q <= mem_b[head.addr[2]];
		rd11_q <= mem_b[head.addr[3]];
	end

	// weight divider: one integer bit up front, then fraction bits per stage
	logic                    vld_q [STEPS+1];
	psfi_pkg::qctl_t         ctl_q [STEPS+1];
	psfi_pkg::dv_t           dvx_q [STEPS+1];
	psfi_pkg::dv_t           dvy_q [STEPS+1];
	psfi_pkg::lane_t [LANES-1:0] ln_q [1:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[0] <= pop && head.query;
			for (int k = 1; k <= STEPS; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_q[0] <= '{unsup: head.unsup, zx: head.zx, zy: head.zy};
		dvx_q[0].q <= T_W'(head.dx >= dw);
		dvx_q[0].r <= (head.dx >= dw) ? D_W'(head.dx - dw) : head.dx;
		dvy_q[0].q <= T_W'(head.dy >= dh);
		dvy_q[0].r <= (head.dy >= dh) ? D_W'(head.dy - dh) : head.dy;
		for (int k = 1; k <= STEPS; k++) begin
			ctl_q[k] <= ctl_q[k-1];
			dvx_q[k] <= psfi_pkg::div_stage(dvx_q[k-1], dw);
			dvy_q[k] <= psfi_pkg::div_stage(dvy_q[k-1], dh);
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < LANES; p++) begin
			ln_q[1][p].v00 <= rd00_q[p];
			ln_q[1][p].v10 <= rd10_q[p];
			ln_q[1][p].dy0 <= DIF_W'($signed(rd01_q[p])) - DIF_W'($signed(rd00_q[p]));
			ln_q[1][p].dy1 <= DIF_W'($signed(rd11_q[p])) - DIF_W'($signed(rd10_q[p]));
		end
		for (int k = 2; k <= STEPS; k++) begin
			ln_q[k] <= ln_q[k-1];
		end
	end

	// round weights: halves up once the remainder reaches half the spacing
	logic                        vld_s2;
	psfi_pkg::qctl_t             ctl_s2;
	logic [T_W-1:0]              tx_s2, ty_s2;
	psfi_pkg::lane_t [LANES-1:0] ln_s2;

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_q[STEPS];
		ln_s2  <= ln_q[STEPS];
		tx_s2  <= ctl_q[STEPS].zx ? '0 :
		          T_W'(dvx_q[STEPS].q + T_W'(dvx_q[STEPS].r >= D_W'(wp)));
		ty_s2  <= ctl_q[STEPS].zy ? '0 :
		          T_W'(dvy_q[STEPS].q + T_W'(dvy_q[STEPS].r >= D_W'(hp)));
	end

	// a = v00 + (v01-v00)*ty, b = v10 + (v11-v10)*ty, S = a + (b-a)*tx
	logic                     vld_s3, vld_s4, vld_s5, vld_s6;
	psfi_pkg::qctl_t          ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [T_W-1:0]           tx_s3, tx_s4;
	logic signed [A_W-1:0]    a_s3 [LANES];
	logic signed [A_W-1:0]    b_s3 [LANES];
	logic signed [A_W-1:0]    a_s4 [LANES];
	logic signed [A_W-1:0]    e_s4 [LANES];
	logic signed [A_W-1:0]    a_s5 [LANES];
	logic [SPLIT+T_W-1:0]     plo_s5 [LANES];
	logic signed [A_W-SPLIT+T_W:0] phi_s5 [LANES];
	logic signed [S_W-1:0]    sum_s6 [LANES];

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_s2;
		tx_s3  <= tx_s2;
		ctl_s4 <= ctl_s3;
		tx_s4  <= tx_s3;
		ctl_s5 <= ctl_s4;
		ctl_s6 <= ctl_s5;
		for (int p = 0; p < LANES; p++) begin
			a_s3[p] <= (A_W'($signed(ln_s2[p].v00)) <<< WB) +
			           A_W'($signed(ln_s2[p].dy0) * $signed({1'b0, ty_s2}));
			b_s3[p] <= (A_W'($signed(ln_s2[p].v10)) <<< WB) +
			           A_W'($signed(ln_s2[p].dy1) * $signed({1'b0, ty_s2}));
			a_s4[p] <= a_s3[p];
			e_s4[p] <= b_s3[p] - a_s3[p];
			a_s5[p] <= a_s4[p];
			plo_s5[p] <= (SPLIT+T_W)'(e_s4[p][SPLIT-1:0] * tx_s4);
			phi_s5[p] <= $signed(e_s4[p][A_W-1:SPLIT]) * $signed({1'b0, tx_s4});
			sum_s6[p] <= (S_W'(a_s5[p]) <<< WB) + (S_W'(phi_s5[p]) <<< SPLIT) +
			             $signed(S_W'(plo_s5[p]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s2 <= vld_q[STEPS];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// round halves up, saturate
	logic                  done_q;
	logic                  status_q;
	psfi_pkg::pvec_t       res_q;
	logic signed [S_W-1:0] rb [LANES];
	logic signed [R_W-1:0] rnd [LANES];
	psfi_pkg::pvec_t       res_n;

	always_comb begin
		for (int p = 0; p < LANES; p++) begin
			rb[p]  = sum_s6[p] + (S_W'(1) <<< (2 * WB - 1));
			rnd[p] = rb[p][S_W-1:2*WB];
			if (ctl_s6.unsup) begin
				res_n[p] = '0;
			end else if (rnd[p] > RMAX) begin
				res_n[p] = PARAM_W'(RMAX);
			end else if (rnd[p] < RMIN) begin
				res_n[p] = PARAM_W'(RMIN);
			end else begin
				res_n[p] = PARAM_W'(rnd[p]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_n;
		status_q <= ctl_s6.unsup;
	end

	assign done   = done_q;
	assign terms  = res_q;
	assign status = status_q;

	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q) |-> (res_q == '0))
		else $error("unsupported grid word with nonzero terms");

	a_query_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.query) |-> ##LAT done_q)
		else $error("query word did not complete on time");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && head.query) |-> ##LAT !done_q)
		else $error("result word without a query");

endmodule
